FILE: rtl/core/slpe_pkg.sv
// shared codes, types, timing constants and pattern functions of the status led evaluator
package slpe_pkg;

  localparam int unsigned TIME_WIDTH_DEF = 64;

  // overlay codes
  localparam logic [2:0] OV_NONE     = 3'd0;
  localparam logic [2:0] OV_IDENTIFY = 3'd1;
  localparam logic [2:0] OV_ACTIVITY = 3'd2;
  localparam logic [2:0] OV_FACTORY  = 3'd3;
  localparam logic [2:0] OV_RESTART  = 3'd4;

  // board status codes
  localparam logic [2:0] ST_BOOTING  = 3'd0;
  localparam logic [2:0] ST_PROV     = 3'd1;
  localparam logic [2:0] ST_CONNECT  = 3'd2;
  localparam logic [2:0] ST_READY    = 3'd3;
  localparam logic [2:0] ST_DEGRADED = 3'd4;
  localparam logic [2:0] ST_ERROR    = 3'd5;

  // blink periods and lit times in ms
  localparam logic [9:0] P_BOOT = 10'd200;
  localparam logic [9:0] L_BOOT = 10'd100;
  localparam logic [9:0] P_IDF  = 10'd500;
  localparam logic [9:0] L_IDF  = 10'd250;
  localparam logic [9:0] P_PROV = 10'd1000;
  localparam logic [9:0] L_PROV = 10'd500;
  localparam logic [9:0] P_CONN = 10'd250;
  localparam logic [9:0] L_CONN = 10'd125;
  localparam logic [9:0] P_DEGR = 10'd1000;
  localparam logic [9:0] L_DEGR = 10'd150;

  // error triple blink, edges within its 1750 ms cycle
  localparam logic [10:0] ERR_PERIOD = 11'd1750;
  localparam logic [10:0] ERR_E1     = 11'd150;
  localparam logic [10:0] ERR_E2     = 11'd300;
  localparam logic [10:0] ERR_E3     = 11'd450;
  localparam logic [10:0] ERR_E4     = 11'd600;
  localparam logic [10:0] ERR_E5     = 11'd750;

  // elapsed mod 7000 covers every period; 7000 = 8 * 875
  localparam int unsigned RED_MOD  = 875;
  localparam int unsigned SPAN     = 8 * RED_MOD;
  localparam int unsigned CHK_W    = 10;
  localparam int unsigned PRD_W    = 2 * CHK_W;
  // at most seven weighted chunks: 7 * 1023 * 874 stays below 2^23
  localparam int unsigned SUM_W    = 23;
  localparam int unsigned RECIP_SH = SUM_W;
  localparam int unsigned RECIP    = (1 << RECIP_SH) / RED_MOD;
  localparam int unsigned RCP_W    = 14;
  localparam int unsigned Q_W      = 13;
  localparam int unsigned V_W      = 13;

  typedef enum logic [2:0] {
    PAT_B200,
    PAT_B500,
    PAT_B1000H,
    PAT_B250,
    PAT_B1000D,
    PAT_ERR,
    PAT_ON,
    PAT_OFF
  } pat_t;

  typedef struct packed {
    pat_t       pat;
    logic [2:0] eff;
  } meta_t;

  typedef struct packed {
    logic       led;
    logic       chg;
    logic [9:0] wait_ms;
  } led_res_t;

  // 2^k mod 875, elaboration only
  function automatic int unsigned pow2_mod(int unsigned k);
    int unsigned w;
    w = 1;
    for (int unsigned i = 0; i < k; i++) begin
      w = w * 2;
      if (w >= RED_MOD) begin
        w = w - RED_MOD;
      end
    end
    return w;
  endfunction

  function automatic led_res_t blink(logic [9:0] ph, logic [9:0] period, logic [9:0] lit_ms);
    led_res_t r;
    r.chg = 1'b1;
    if (ph < lit_ms) begin
      r.led     = 1'b1;
      r.wait_ms = lit_ms - ph;
    end else begin
      r.led     = 1'b0;
      r.wait_ms = period - ph;
    end
    return r;
  endfunction

  function automatic led_res_t error_pat(logic [10:0] p);
    led_res_t    r;
    logic [10:0] lim;
    r.chg = 1'b1;
    if (p < ERR_E1) begin
      r.led = 1'b1;
      lim   = ERR_E1;
    end else if (p < ERR_E2) begin
      r.led = 1'b0;
      lim   = ERR_E2;
    end else if (p < ERR_E3) begin
      r.led = 1'b1;
      lim   = ERR_E3;
    end else if (p < ERR_E4) begin
      r.led = 1'b0;
      lim   = ERR_E4;
    end else if (p < ERR_E5) begin
      r.led = 1'b1;
      lim   = ERR_E5;
    end else begin
      r.led = 1'b0;
      lim   = ERR_PERIOD;
    end
    r.wait_ms = 10'(lim - p);
    return r;
  endfunction

endpackage

FILE: rtl/core/status_led_pattern_evaluator.sv
// status led pattern evaluator: pipelined elapsed-time residue and pattern lookup
//
// Input channel in_*: one query per beat (status, overlay request, activity
// flags, current time and pattern epoch in ms). Result channel out_*: one
// result per query, in order (led state, overlay in effect, next edge flag
// and ms to the next edge).
// Throughput: one beat per cycle on both channels while out_ready stays high.
// An accepted beat crosses eight register stages on its way to out_valid,
// the input register included. The depth is set by the residue path:
// elapsed subtract, weighted 10-bit chunk products, their sum, a reciprocal
// multiply, remainder correction, period folding and the final pattern select,
// one register stage each.
// Reset (rst_n low, synchronous) empties the pipeline; out_valid drops and
// in_ready rises in the next cycle.
// A stalled receiver holds the result in the output stage; bubbles ahead of
// it are still filled, and in_ready falls only once every stage is full.
module status_led_pattern_evaluator #(
  parameter int unsigned TIME_WIDTH = slpe_pkg::TIME_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            in_board_status,
  input  logic [2:0]            in_overlay,
  input  logic                  in_identify_on,
  input  logic                  in_activity_on,
  input  logic [TIME_WIDTH-1:0] in_now_time,
  input  logic [TIME_WIDTH-1:0] in_epoch_time,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_led_on,
  output logic [2:0]            out_effective_overlay,
  output logic                  out_has_change,
  output logic [9:0]            out_next_change_ms
);
  import slpe_pkg::*;

  localparam int unsigned NSTG = 8;
  localparam int unsigned YW   = TIME_WIDTH - 3;
  localparam int unsigned NCHK = (YW + CHK_W - 1) / CHK_W;
  localparam int unsigned YPW  = NCHK * CHK_W;

  // stage handshake
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] adv;

  always_comb begin
    adv[NSTG-1] = !vld_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
    vld_nxt = vld_r;
    for (int k = 0; k < NSTG; k++) begin
      if (adv[k]) begin
        vld_nxt[k] = (k == 0) ? in_valid : vld_r[(k == 0) ? 0 : k - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld_r[NSTG-1];

  // stage 0: input register
  logic [2:0]            sts0_r;
  logic [2:0]            ov0_r;
  logic                  idf0_r;
  logic                  act0_r;
  logic [TIME_WIDTH-1:0] now0_r;
  logic [TIME_WIDTH-1:0] epc0_r;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      sts0_r <= in_board_status;
      ov0_r  <= in_overlay;
      idf0_r <= in_identify_on;
      act0_r <= in_activity_on;
      now0_r <= in_now_time;
      epc0_r <= in_epoch_time;
    end
  end

  // stage 1: elapsed time and pattern choice
  meta_t                 meta1_nxt;
  meta_t                 meta1_r;
  logic [TIME_WIDTH-1:0] elp1_r;

  always_comb begin
    meta1_nxt.eff = OV_NONE;
    if (ov0_r == OV_FACTORY) begin
      meta1_nxt.pat = PAT_B200;
      meta1_nxt.eff = OV_FACTORY;
    end else if (ov0_r == OV_RESTART) begin
      meta1_nxt.pat = PAT_ON;
      meta1_nxt.eff = OV_RESTART;
    end else if (sts0_r == ST_ERROR) begin
      meta1_nxt.pat = PAT_ERR;
    end else if (ov0_r == OV_IDENTIFY && idf0_r) begin
      meta1_nxt.pat = PAT_B500;
      meta1_nxt.eff = OV_IDENTIFY;
    end else if (ov0_r == OV_ACTIVITY && act0_r) begin
      meta1_nxt.pat = PAT_ON;
      meta1_nxt.eff = OV_ACTIVITY;
    end else begin
      case (sts0_r)
        ST_BOOTING:  meta1_nxt.pat = PAT_B200;
        ST_PROV:     meta1_nxt.pat = PAT_B1000H;
        ST_CONNECT:  meta1_nxt.pat = PAT_B250;
        ST_READY:    meta1_nxt.pat = PAT_ON;
        ST_DEGRADED: meta1_nxt.pat = PAT_B1000D;
        default:     meta1_nxt.pat = PAT_OFF;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      meta1_r <= meta1_nxt;
      elp1_r  <= now0_r - epc0_r;
    end
  end

  // stage 2: elapsed/8 split into 10-bit chunks, each scaled by 2^(10i) mod 875
  logic [YPW-1:0]   y_pad;
  logic [PRD_W-1:0] prd_nxt [NCHK];
  logic [PRD_W-1:0] prd2_r  [NCHK];
  logic [2:0]       e3_2_r;
  meta_t            meta2_r;

  assign y_pad = YPW'(elp1_r >> 3);

  for (genvar i = 0; i < NCHK; i++) begin : g_chk
    localparam logic [CHK_W-1:0] WGT = CHK_W'(pow2_mod(CHK_W * i));
    assign prd_nxt[i] = PRD_W'(y_pad[i*CHK_W +: CHK_W]) * PRD_W'(WGT);
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      prd2_r  <= prd_nxt;
      e3_2_r  <= elp1_r[2:0];
      meta2_r <= meta1_r;
    end
  end

  // stage 3: sum of the chunk products, congruent to elapsed/8 mod 875
  logic [SUM_W-1:0] sum_nxt;
  logic [SUM_W-1:0] sum3_r;
  logic [2:0]       e3_3_r;
  meta_t            meta3_r;

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < NCHK; i++) begin
      sum_nxt = sum_nxt + SUM_W'(prd2_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      sum3_r  <= sum_nxt;
      e3_3_r  <= e3_2_r;
      meta3_r <= meta2_r;
    end
  end

  // stage 4: quotient estimate by reciprocal, low by at most one
  logic [SUM_W+RCP_W-1:0] qp_nxt;
  logic [Q_W-1:0]         q4_r;
  logic [SUM_W-1:0]       sum4_r;
  logic [2:0]             e3_4_r;
  meta_t                  meta4_r;

  assign qp_nxt = (SUM_W + RCP_W)'(sum3_r) * (SUM_W + RCP_W)'(RECIP);

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      q4_r    <= Q_W'(qp_nxt >> RECIP_SH);
      sum4_r  <= sum3_r;
      e3_4_r  <= e3_3_r;
      meta4_r <= meta3_r;
    end
  end

  // stage 5: remainder with one correction, then elapsed mod 7000
  logic [SUM_W-1:0] qm;
  logic [SUM_W-1:0] rem;
  logic [10:0]      rem11;
  logic [9:0]       r875;
  logic [V_W-1:0]   v5_r;
  meta_t            meta5_r;

  always_comb begin
    qm    = SUM_W'(q4_r) * SUM_W'(RED_MOD);
    rem   = sum4_r - qm;
    rem11 = 11'(rem);
    r875  = (rem11 >= 11'(RED_MOD)) ? 10'(rem11 - 11'(RED_MOD)) : 10'(rem11);
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      v5_r    <= {r875, e3_4_r};
      meta5_r <= meta4_r;
    end
  end

  // stage 6: phase within each period
  logic [V_W-1:0] b1000;
  logic [V_W-1:0] b1750;
  logic [9:0]     m1000_nxt;
  logic [9:0]     b200;
  logic [9:0]     b250;
  logic [10:0]    m1750_6_r;
  logic [9:0]     m1000_6_r;
  logic [8:0]     m500_6_r;
  logic [7:0]     m250_6_r;
  logic [7:0]     m200_6_r;
  meta_t          meta6_r;

  always_comb begin
    b1000 = '0;
    for (int k = 1; k < int'(SPAN / 1000); k++) begin
      if (v5_r >= V_W'(k * 1000)) begin
        b1000 = V_W'(k * 1000);
      end
    end
    b1750 = '0;
    for (int k = 1; k < int'(SPAN / 1750); k++) begin
      if (v5_r >= V_W'(k * 1750)) begin
        b1750 = V_W'(k * 1750);
      end
    end
    m1000_nxt = 10'(v5_r - b1000);
    b200 = '0;
    for (int k = 1; k < 5; k++) begin
      if (m1000_nxt >= 10'(k * 200)) begin
        b200 = 10'(k * 200);
      end
    end
    b250 = '0;
    for (int k = 1; k < 4; k++) begin
      if (m1000_nxt >= 10'(k * 250)) begin
        b250 = 10'(k * 250);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      m1750_6_r <= 11'(v5_r - b1750);
      m1000_6_r <= m1000_nxt;
      m500_6_r  <= (m1000_nxt >= P_IDF) ? 9'(m1000_nxt - P_IDF) : 9'(m1000_nxt);
      m250_6_r  <= 8'(m1000_nxt - b250);
      m200_6_r  <= 8'(m1000_nxt - b200);
      meta6_r   <= meta5_r;
    end
  end

  // stage 7: pattern evaluation into the output register
  led_res_t   res_nxt;
  logic       led7_r;
  logic [2:0] eff7_r;
  logic       chg7_r;
  logic [9:0] until7_r;

  always_comb begin
    case (meta6_r.pat)
      PAT_B200:   res_nxt = blink(10'(m200_6_r), P_BOOT, L_BOOT);
      PAT_B500:   res_nxt = blink(10'(m500_6_r), P_IDF, L_IDF);
      PAT_B1000H: res_nxt = blink(m1000_6_r, P_PROV, L_PROV);
      PAT_B250:   res_nxt = blink(10'(m250_6_r), P_CONN, L_CONN);
      PAT_B1000D: res_nxt = blink(m1000_6_r, P_DEGR, L_DEGR);
      PAT_ERR:    res_nxt = error_pat(m1750_6_r);
      PAT_ON:     res_nxt = '{led: 1'b1, chg: 1'b0, wait_ms: 10'd0};
      default:    res_nxt = '{led: 1'b0, chg: 1'b0, wait_ms: 10'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      led7_r   <= res_nxt.led;
      eff7_r   <= meta6_r.eff;
      chg7_r   <= res_nxt.chg;
      until7_r <= res_nxt.wait_ms;
    end
  end

  assign out_led_on            = led7_r;
  assign out_effective_overlay = eff7_r;
  assign out_has_change        = chg7_r;
  assign out_next_change_ms    = until7_r;

  // input side only backs up when every stage holds a beat and the receiver stalls
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("in_ready low without a full stalled pipeline");

  a_steady_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_change) |-> (out_next_change_ms == 10'd0))
    else $error("steady result with nonzero time to next edge");

  a_edge_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_has_change) |->
      (out_next_change_ms != 10'd0 && out_next_change_ms <= P_PROV))
    else $error("time to next edge out of range");

  a_restart_on: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_effective_overlay == OV_RESTART) |-> (out_led_on && !out_has_change))
    else $error("restart overlay not steady on");

endmodule

FILE: tb/tb.sv
// self-checking testbench for the status led pattern evaluator
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slpe_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned TAIL_ITEMS  = 80;
  localparam int unsigned DRAIN_WAIT  = 20;
  localparam int unsigned N_RANDOM    = 750;

  typedef struct {
    logic [2:0]  board_status;
    logic [2:0]  overlay;
    logic        identify_on;
    logic        activity_on;
    logic [63:0] now_time;
    logic [63:0] epoch_time;
  } query_t;

  typedef struct {
    logic       led;
    logic [2:0] eff;
    logic       chg;
    logic [9:0] wait_ms;
  } led_exp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_board_status = '0;
  logic [2:0]  in_overlay = '0;
  logic        in_identify_on = 1'b0;
  logic        in_activity_on = 1'b0;
  logic [63:0] in_now_time = '0;
  logic [63:0] in_epoch_time = '0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic        out_led_on;
  logic [2:0]  out_effective_overlay;
  logic        out_has_change;
  logic [9:0]  out_next_change_ms;

  query_t   pending_queries[$];
  led_exp_t expected_leds[$];
  query_t   cur_query;
  int unsigned n_queued = 0;
  int unsigned n_accepted = 0;
  int unsigned n_errors = 0;
  int unsigned cycles = 0;
  int unsigned gap_left = 0;
  int unsigned quiet_left = 0;
  int unsigned stall_left = 0;

  status_led_pattern_evaluator dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_board_status       (in_board_status),
    .in_overlay            (in_overlay),
    .in_identify_on        (in_identify_on),
    .in_activity_on        (in_activity_on),
    .in_now_time           (in_now_time),
    .in_epoch_time         (in_epoch_time),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_led_on            (out_led_on),
    .out_effective_overlay (out_effective_overlay),
    .out_has_change        (out_has_change),
    .out_next_change_ms    (out_next_change_ms)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    n_errors++;
    if (n_errors <= 50) begin
      $display("mismatch at cycle %0d: %s, got %0d, expected %0d", cycles, what, got, want);
    end
  endtask

  function automatic led_exp_t steady_led(logic lit);
    led_exp_t r;
    r.led     = lit;
    r.eff     = OV_NONE;
    r.chg     = 1'b0;
    r.wait_ms = '0;
    return r;
  endfunction

  function automatic led_exp_t blink_at(logic [63:0] el, logic [9:0] period,
                                        logic [9:0] lit_ms);
    led_exp_t   r;
    logic [9:0] ph;
    ph    = 10'(el % 64'(period));
    r.eff = OV_NONE;
    r.chg = 1'b1;
    if (ph < lit_ms) begin
      r.led     = 1'b1;
      r.wait_ms = lit_ms - ph;
    end else begin
      r.led     = 1'b0;
      r.wait_ms = period - ph;
    end
    return r;
  endfunction

  // three lit pulses, then a long dark stretch
  function automatic led_exp_t triple_blink_at(logic [63:0] el);
    led_exp_t    r;
    logic [10:0] p;
    logic [10:0] bound;
    p     = 11'(el % 64'(ERR_PERIOD));
    r.eff = OV_NONE;
    r.chg = 1'b1;
    if (p < ERR_E1) begin
      r.led = 1'b1;
      bound = ERR_E1;
    end else if (p < ERR_E2) begin
      r.led = 1'b0;
      bound = ERR_E2;
    end else if (p < ERR_E3) begin
      r.led = 1'b1;
      bound = ERR_E3;
    end else if (p < ERR_E4) begin
      r.led = 1'b0;
      bound = ERR_E4;
    end else if (p < ERR_E5) begin
      r.led = 1'b1;
      bound = ERR_E5;
    end else begin
      r.led = 1'b0;
      bound = ERR_PERIOD;
    end
    r.wait_ms = 10'(bound - p);
    return r;
  endfunction

  function automatic led_exp_t predict_led(query_t q);
    logic [63:0] el;
    led_exp_t    r;
    el = q.now_time - q.epoch_time;
    if (q.overlay == OV_FACTORY) begin
      r     = blink_at(el, P_BOOT, L_BOOT);
      r.eff = OV_FACTORY;
    end else if (q.overlay == OV_RESTART) begin
      r     = steady_led(1'b1);
      r.eff = OV_RESTART;
    end else if (q.board_status == ST_ERROR) begin
      r = triple_blink_at(el);
    end else if (q.overlay == OV_IDENTIFY && q.identify_on) begin
      r     = blink_at(el, P_IDF, L_IDF);
      r.eff = OV_IDENTIFY;
    end else if (q.overlay == OV_ACTIVITY && q.activity_on) begin
      r     = steady_led(1'b1);
      r.eff = OV_ACTIVITY;
    end else begin
      case (q.board_status)
        ST_BOOTING:  r = blink_at(el, P_BOOT, L_BOOT);
        ST_PROV:     r = blink_at(el, P_PROV, L_PROV);
        ST_CONNECT:  r = blink_at(el, P_CONN, L_CONN);
        ST_READY:    r = steady_led(1'b1);
        ST_DEGRADED: r = blink_at(el, P_DEGR, L_DEGR);
        default:     r = steady_led(1'b0);
      endcase
    end
    return r;
  endfunction

  task automatic add_query(logic [2:0] st, logic [2:0] ov, logic idf, logic act,
                           logic [63:0] now, logic [63:0] epoch);
    query_t q;
    q.board_status = st;
    q.overlay      = ov;
    q.identify_on  = idf;
    q.activity_on  = act;
    q.now_time     = now;
    q.epoch_time   = epoch;
    pending_queries.push_back(q);
    n_queued++;
  endtask

  // random epoch, with the now time set to epoch plus elapsed
  task automatic add_elapsed(logic [2:0] st, logic [2:0] ov, logic idf, logic act,
                             logic [63:0] el);
    logic [63:0] ep;
    ep = {$urandom, $urandom};
    add_query(st, ov, idf, act, ep + el, ep);
  endtask

  // input side
  always @(posedge clk) begin : drive
    logic busy;
    busy = in_valid;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_leds.push_back(predict_led(cur_query));
        n_accepted++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_queries.size() > 0) begin
          cur_query       = pending_queries.pop_front();
          in_board_status <= cur_query.board_status;
          in_overlay      <= cur_query.overlay;
          in_identify_on  <= cur_query.identify_on;
          in_activity_on  <= cur_query.activity_on;
          in_now_time     <= cur_query.now_time;
          in_epoch_time   <= cur_query.epoch_time;
          busy = 1'b1;
          if (quiet_left > 0) begin
            quiet_left--;
          end else if ($urandom_range(0, 49) == 0) begin
            quiet_left = $urandom_range(20, 60);
          end else if (pending_queries.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(1, 6);
          end
        end
      end
      in_valid <= busy;
    end
  end

  // result side
  always @(posedge clk) begin : check
    led_exp_t e;
    logic     rdy;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_leds.size() == 0) begin
          report_mismatch("result beat with no query outstanding", 64'd1, 64'd0);
        end else begin
          e = expected_leds.pop_front();
          if (out_led_on !== e.led)
            report_mismatch("led_on", 64'(out_led_on), 64'(e.led));
          if (out_effective_overlay !== e.eff)
            report_mismatch("effective_overlay", 64'(out_effective_overlay), 64'(e.eff));
          if (out_has_change !== e.chg)
            report_mismatch("has_change", 64'(out_has_change), 64'(e.chg));
          if (out_next_change_ms !== e.wait_ms)
            report_mismatch("next_change_ms", 64'(out_next_change_ms), 64'(e.wait_ms));
        end
      end
      rdy = 1'b1;
      if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (quiet_left == 0 && pending_queries.size() > TAIL_ITEMS &&
                   $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 5);
        rdy = 1'b0;
      end
      out_ready <= rdy;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [63:0] el;
    logic [63:0] ep;
    int unsigned waited;

    // directed: every status, every overlay, pattern edges, time extremes
    add_elapsed(ST_BOOTING,  OV_NONE,     1'b0, 1'b0, 64'd99);
    add_elapsed(ST_BOOTING,  3'd5,        1'b1, 1'b1, 64'd100);
    add_elapsed(ST_PROV,     OV_NONE,     1'b0, 1'b0, 64'd999);
    add_elapsed(ST_CONNECT,  3'd6,        1'b0, 1'b1, 64'd124);
    add_elapsed(ST_READY,    OV_NONE,     1'b0, 1'b0, 64'd123456);
    add_elapsed(ST_DEGRADED, 3'd7,        1'b1, 1'b0, 64'd150);
    add_elapsed(ST_ERROR,    OV_NONE,     1'b0, 1'b0, 64'd149);
    add_elapsed(ST_ERROR,    OV_NONE,     1'b0, 1'b0, 64'd750);
    add_elapsed(ST_ERROR,    OV_NONE,     1'b0, 1'b0, 64'd1749);
    add_elapsed(3'd6,        OV_NONE,     1'b1, 1'b1, 64'd10);
    add_elapsed(3'd7,        OV_NONE,     1'b0, 1'b0, 64'd0);
    add_elapsed(ST_BOOTING,  OV_IDENTIFY, 1'b1, 1'b0, 64'd499);
    add_elapsed(ST_CONNECT,  OV_IDENTIFY, 1'b0, 1'b1, 64'd250);
    add_elapsed(ST_PROV,     OV_ACTIVITY, 1'b0, 1'b1, 64'd77);
    add_elapsed(ST_DEGRADED, OV_ACTIVITY, 1'b1, 1'b0, 64'd0);
    add_elapsed(ST_READY,    OV_FACTORY,  1'b0, 1'b0, 64'd199);
    add_elapsed(ST_ERROR,    OV_RESTART,  1'b1, 1'b1, 64'd5);
    add_elapsed(ST_ERROR,    OV_IDENTIFY, 1'b1, 1'b1, 64'd300);
    add_elapsed(ST_ERROR,    OV_FACTORY,  1'b0, 1'b0, 64'd100);
    add_elapsed(ST_ERROR,    OV_ACTIVITY, 1'b0, 1'b1, 64'd600);
    add_query(ST_PROV,    OV_NONE,    1'b0, 1'b0, 64'd5, 64'd100);
    add_query(ST_BOOTING, OV_FACTORY, 1'b0, 1'b0, '1, '0);
    add_query(ST_CONNECT, OV_NONE,    1'b0, 1'b0, '0, '1);
    add_query(ST_ERROR,   OV_NONE,    1'b0, 1'b0, '1, '1);

    for (int i = 0; i < N_RANDOM; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: el = 64'($urandom_range(0, 7999));
        4, 5, 6: begin
          // land on or next to a pattern edge, often many periods in
          case ($urandom_range(0, 12))
            0:  el = 64'd0;
            1:  el = 64'd100;
            2:  el = 64'd125;
            3:  el = 64'd150;
            4:  el = 64'd200;
            5:  el = 64'd250;
            6:  el = 64'd300;
            7:  el = 64'd450;
            8:  el = 64'd500;
            9:  el = 64'd600;
            10: el = 64'd750;
            11: el = 64'd1000;
            default: el = 64'd1750;
          endcase
          el = el + 64'd7000 * 64'($urandom) * 64'($urandom_range(0, 3)) - 64'd1
               + 64'($urandom_range(0, 2));
        end
        default: el = {$urandom, $urandom};
      endcase
      ep = {$urandom, $urandom};
      add_query(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), ep + el, ep);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (n_accepted != n_queued) @(posedge clk);
    waited = 0;
    while (expected_leds.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_leds.size() != 0) begin
      report_mismatch("queries left without a result", 64'(expected_leds.size()), 64'd0);
    end

    if (n_errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
